### rtl/fordec_pkg.sv
// ----------------------------------------------------------------------------
// fordec_pkg
// Shared types and constants of the file-order run decoder.
// ----------------------------------------------------------------------------
package fordec_pkg;

  // default width of a decoded number
  localparam int NUMBER_BITS_DEF = 32;

  // largest file count the decoder is built for
  localparam int MAX_FILES = 65536;

  // positions and entry totals may not exceed this, whatever the file count
  localparam logic [16:0] LIMIT_CAP = (MAX_FILES < 65536) ? 17'(MAX_FILES) : 17'd65536;

  // current position saturates here, at or above any limit
  localparam logic [16:0] POS_SAT = 17'h1FFFF;

  // nibble layout: three value bits, then the continuation flag
  localparam int VAL_BITS = 3;
  localparam int CONT_BIT = 3;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // one nibble word handed from front to back
  typedef struct packed {
    logic [3:0] nib;
    logic       lo;   // second nibble of its byte
    logic       fin;  // byte is the final one of the sequence
  } nib_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [16:0] len;
    logic [16:0] total;
  } result_t;

endpackage

### rtl/file_order_run_decoder_unit.sv
// ----------------------------------------------------------------------------
// file_order_run_decoder_unit
// Decodes the compressed file-order byte stream into runs of file positions
// with a final status word per sequence.
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_seq_byte, in_last_byte
// out_      output     out_valid / out_stall out_result_kind, out_run_start,
//                                           out_run_length, out_total_entries,
//                                           out_last
// cfg_      input      cfg_valid / cfg_ready cfg_file_count
//
// the front splits each byte into two nibble words and takes the next byte
// as the low nibble leaves; the back decodes one nibble a cycle unless the
// queue is empty or a stalled output holds it; a final byte that ends in a
// status word costs one more back step.
// reset clears all decode state and the file count to zero; no clearing pass.
// a stalled output holds its word; the two-entry nibble queue keeps the
// front taking bytes while the back waits.
// ----------------------------------------------------------------------------
module file_order_run_decoder_unit #(
  parameter int NUMBER_BITS = fordec_pkg::NUMBER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_seq_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_run_start,
  output logic [16:0] out_run_length,
  output logic [16:0] out_total_entries,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_file_count
);

  import fordec_pkg::*;

  localparam int ENTRY_W = $bits(nib_entry_t);

  logic [16:0]  limit_r, limit_nxt;
  logic         q_push, q_full, q_pop, q_empty;
  nib_entry_t   q_in, q_head;
  logic [ENTRY_W-1:0] q_head_bits;
  result_t      res;

  assign cfg_ready = 1'b1;

  // only the clipped limit is ever needed
  assign limit_nxt = (cfg_file_count > LIMIT_CAP) ? LIMIT_CAP : cfg_file_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= limit_nxt;
    end
  end

  fordec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_seq_byte  (in_seq_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  fordec_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head_bits),
    .empty     (q_empty)
  );

  assign q_head = nib_entry_t'(q_head_bits);

  fordec_back #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .limit     (limit_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_result_kind   = res.kind;
  assign out_run_start     = res.start;
  assign out_run_length    = res.len;
  assign out_total_entries = res.total;

endmodule

### rtl/fordec_fifo.sv
// ----------------------------------------------------------------------------
// fordec_fifo
// Small register queue that decouples the byte splitter from the decoder.
// ----------------------------------------------------------------------------
module fordec_fifo #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/fordec_front.sv
// ----------------------------------------------------------------------------
// fordec_front
// Takes sequence bytes and splits each into two nibble words, high first.
// ----------------------------------------------------------------------------
module fordec_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_seq_byte,
  input  logic                   in_last_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output fordec_pkg::nib_entry_t q_data
);

  import fordec_pkg::*;

  logic [7:0] byte_r;
  logic       fin_r;
  logic       valid_r, valid_nxt;
  logic       half_r, half_nxt;
  logic       accept;

  assign q_push   = valid_r && !q_full;
  // free again once the low nibble leaves this cycle
  assign in_stall = valid_r && !(q_push && half_r);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    q_data.nib = half_r ? byte_r[3:0] : byte_r[7:4];
    q_data.lo  = half_r;
    q_data.fin = fin_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    if (accept) begin
      valid_nxt = 1'b1;
      half_nxt  = 1'b0;
    end else if (q_push) begin
      if (half_r) begin
        valid_nxt = 1'b0;
        half_nxt  = 1'b0;
      end else begin
        half_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_seq_byte;
      fin_r  <= in_last_byte;
    end
  end

endmodule

### rtl/fordec_back.sv
// ----------------------------------------------------------------------------
// fordec_back
// Decodes one nibble word a cycle, unless a stalled output holds it, into
// numbers, runs and sequence status, and drives the result register.
// ----------------------------------------------------------------------------
module fordec_back #(
  parameter int NUMBER_BITS = fordec_pkg::NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  fordec_pkg::nib_entry_t q_head,
  output logic                   q_pop,
  input  logic [16:0]            limit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fordec_pkg::result_t    out_res,
  output logic                   out_last
);

  import fordec_pkg::*;

  localparam int NB    = NUMBER_BITS;
  localparam int SHW   = $clog2(NB + 1);
  localparam int NUM_W = (NB > 17) ? NB : 17;
  localparam int PL_W  = NB + VAL_BITS;

  // decode state
  logic [NB-1:0]  acc_r, acc_nxt;
  logic [SHW-1:0] shift_r, shift_nxt;
  logic           jump_r, jump_nxt;
  logic           emit_r, emit_nxt;
  logic [16:0]    pos_r, pos_nxt;
  logic [16:0]    ecount_r, ecount_nxt;
  logic           failed_r, failed_nxt;
  logic           byte_err_r, byte_err_nxt;
  logic           fin_step_r, fin_step_nxt;

  // result held until it is known whether it closes its byte
  logic           held_v_r, held_v_nxt;
  logic           held_res_r, held_res_nxt;
  logic           held_last_r, held_last_nxt;
  result_t        held_r, held_nxt;

  logic           out_valid_r, out_valid_nxt;
  result_t        out_r;
  logic           out_last_r, out_last_nxt;

  // nibble evaluation
  logic [VAL_BITS-1:0] v;
  logic                cont;
  logic [PL_W-1:0]     placed;
  logic                wide_err;
  logic [NB-1:0]       acc_new;
  logic [NUM_W-1:0]    number_ext;
  logic                big;
  logic [16:0]         n17;
  logic [17:0]         pos_sum, ec_sum;
  logic [SHW:0]        sh_sum;
  logic                run_err;
  logic                active;

  logic [NB-1:0]  nb_acc;
  logic [SHW-1:0] nb_shift;
  logic           nb_jump, nb_emit, nb_failed;
  logic [16:0]    nb_pos, nb_ecount;
  logic           nres_v, nerr;
  result_t        nres;

  // step control
  logic    out_free, can_step, load_out, fin_res, do_clear;
  logic    held_out_last;

  always_comb begin
    v          = q_head.nib[VAL_BITS-1:0];
    cont       = q_head.nib[CONT_BIT];
    placed     = PL_W'(v) << shift_r;
    wide_err   = |placed[PL_W-1:NB];
    acc_new    = acc_r | placed[NB-1:0];
    number_ext = NUM_W'(acc_new);
    big        = (number_ext >> 17) != '0;
    n17        = number_ext[16:0];
    pos_sum    = {1'b0, pos_r} + {1'b0, n17};
    ec_sum     = {1'b0, ecount_r} + {1'b0, n17};
    sh_sum     = {1'b0, shift_r} + (SHW+1)'(VAL_BITS);
    run_err    = big || (ec_sum > {1'b0, limit}) || (pos_sum > {1'b0, limit});
    // after an error, the rest of the sequence carries no runs
    active     = !failed_r && !(q_head.lo && byte_err_r);
  end

  always_comb begin
    nb_acc    = acc_r;
    nb_shift  = shift_r;
    nb_jump   = jump_r;
    nb_emit   = emit_r;
    nb_pos    = pos_r;
    nb_ecount = ecount_r;
    nb_failed = failed_r;
    nres_v    = 1'b0;
    nerr      = 1'b0;
    nres      = '{kind: KIND_FAIL, start: '0, len: '0, total: ecount_r};
    if (active) begin
      if (wide_err) begin
        nerr      = 1'b1;
        nres_v    = 1'b1;
        nb_failed = 1'b1;
      end else if (cont) begin
        nb_acc   = acc_new;
        nb_shift = (sh_sum > (SHW+1)'(NB)) ? SHW'(NB) : sh_sum[SHW-1:0];
      end else begin
        nb_acc   = '0;
        nb_shift = '0;
        if (jump_r) begin
          nb_pos  = big ? POS_SAT : n17;
          nb_emit = 1'b1;
          nb_jump = 1'b0;
        end else if (acc_new == '0) begin
          // zero marker: next number is an absolute position
          nb_jump = 1'b1;
        end else if (!emit_r) begin
          nb_pos  = (big || pos_sum[17]) ? POS_SAT : pos_sum[16:0];
          nb_emit = 1'b1;
        end else if (run_err) begin
          nerr      = 1'b1;
          nres_v    = 1'b1;
          nb_failed = 1'b1;
        end else begin
          nres_v    = 1'b1;
          nres      = '{kind: KIND_RUN, start: pos_r[15:0], len: n17,
                        total: ec_sum[16:0]};
          nb_ecount = ec_sum[16:0];
          nb_pos    = pos_sum[16:0];
          nb_emit   = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    can_step      = !q_empty && (!held_v_r || out_free);
    fin_res       = q_head.fin && !(byte_err_r || nerr);
    held_out_last = held_res_r ? held_last_r : !(nres_v || fin_res);

    acc_nxt       = acc_r;
    shift_nxt     = shift_r;
    jump_nxt      = jump_r;
    emit_nxt      = emit_r;
    pos_nxt       = pos_r;
    ecount_nxt    = ecount_r;
    failed_nxt    = failed_r;
    byte_err_nxt  = byte_err_r;
    fin_step_nxt  = fin_step_r;
    held_v_nxt    = held_v_r;
    held_res_nxt  = held_res_r;
    held_last_nxt = held_last_r;
    held_nxt      = held_r;
    q_pop         = 1'b0;
    do_clear      = 1'b0;
    load_out      = 1'b0;

    if (can_step) begin
      load_out   = held_v_r;
      held_v_nxt = 1'b0;
      if (fin_step_r) begin
        // end-of-sequence word
        held_v_nxt    = 1'b1;
        held_res_nxt  = 1'b1;
        held_last_nxt = 1'b1;
        held_nxt      = '{kind: (failed_r || shift_r != '0) ? KIND_FAIL : KIND_DONE,
                          start: '0, len: '0, total: ecount_r};
        fin_step_nxt  = 1'b0;
        q_pop         = 1'b1;
        do_clear      = 1'b1;
      end else begin
        acc_nxt    = nb_acc;
        shift_nxt  = nb_shift;
        jump_nxt   = nb_jump;
        emit_nxt   = nb_emit;
        pos_nxt    = nb_pos;
        ecount_nxt = nb_ecount;
        failed_nxt = nb_failed;
        if (nres_v) begin
          held_v_nxt = 1'b1;
          held_nxt   = nres;
        end
        if (q_head.lo) begin
          byte_err_nxt  = 1'b0;
          held_res_nxt  = 1'b1;
          held_last_nxt = !fin_res;
          if (fin_res) begin
            fin_step_nxt = 1'b1;
          end else begin
            q_pop    = 1'b1;
            do_clear = q_head.fin;
          end
        end else begin
          byte_err_nxt = nerr;
          held_res_nxt = 1'b0;
          q_pop        = 1'b1;
        end
      end
    end else if (held_v_r && held_res_r && out_free) begin
      load_out   = 1'b1;
      held_v_nxt = 1'b0;
    end

    if (do_clear) begin
      acc_nxt      = '0;
      shift_nxt    = '0;
      jump_nxt     = 1'b0;
      emit_nxt     = 1'b1;
      pos_nxt      = '0;
      ecount_nxt   = '0;
      failed_nxt   = 1'b0;
      byte_err_nxt = 1'b0;
    end

    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);
    out_last_nxt  = load_out ? held_out_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      shift_r     <= '0;
      jump_r      <= 1'b0;
      emit_r      <= 1'b1;
      pos_r       <= '0;
      ecount_r    <= '0;
      failed_r    <= 1'b0;
      byte_err_r  <= 1'b0;
      fin_step_r  <= 1'b0;
      held_v_r    <= 1'b0;
      held_res_r  <= 1'b0;
      held_last_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      shift_r     <= shift_nxt;
      jump_r      <= jump_nxt;
      emit_r      <= emit_nxt;
      pos_r       <= pos_nxt;
      ecount_r    <= ecount_nxt;
      failed_r    <= failed_nxt;
      byte_err_r  <= byte_err_nxt;
      fin_step_r  <= fin_step_nxt;
      held_v_r    <= held_v_nxt;
      held_res_r  <= held_res_nxt;
      held_last_r <= held_last_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (load_out) begin
      out_r <= held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  // the end-of-sequence step keeps its low nibble word at the queue head
  a_fin_step_head: assert property (@(posedge clk) disable iff (!rst_n)
    fin_step_r |-> (!q_empty && q_head.lo && q_head.fin))
    else $error("end-of-sequence step without its final word at the head");

  // a result from a high nibble waits only for the low nibble of its byte
  a_unresolved_held: assert property (@(posedge clk) disable iff (!rst_n)
    (held_v_r && !held_res_r) |-> (q_empty || q_head.lo))
    else $error("unresolved result while a new byte starts");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r <= SHW'(NB))
    else $error("shift amount beyond number width");

  // a completed sequence leaves the decoder in its start state
  a_clear_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.fin && q_head.lo) |=>
      (shift_r == '0 && ecount_r == '0 && !failed_r && emit_r))
    else $error("decode state not cleared after final byte");

endmodule

### dv/file_order_run_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// file_order_run_decoder_unit_tb
// Feeds compressed file-order bytes to the run decoder and checks every run
// and status word it returns against a cycle-free decoder model kept here.
// Directed checks cover the limits and error paths. Random well-formed and
// broken sequences follow under several file counts, with random idling on
// both sides, one long output hold and a quiet tail.
// ----------------------------------------------------------------------------
module file_order_run_decoder_unit_tb;
  import fordec_pkg::*;

  localparam int NB           = NUMBER_BITS_DEF;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 10;
  localparam int MAX_PRINTS   = 40;

  typedef enum {NIB_NONE, NIB_RUN, NIB_FAIL} nib_outcome_t;
  typedef enum {SEQ_GOOD, SEQ_DANGLING, SEQ_WIDE, SEQ_NOISE} seq_shape_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [16:0] len;
    logic [16:0] total;
    logic        last;
  } decoded_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_seq_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [15:0] out_run_start;
  logic [16:0] out_run_length;
  logic [16:0] out_total_entries;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_file_count;

  // decoder model state
  logic [63:0] m_acc;
  int          m_shift;
  bit          m_jump;
  bit          m_emit_next;
  bit          m_failed;
  logic [63:0] m_pos;
  logic [63:0] m_entries;
  logic [16:0] m_file_count;

  decoded_word_t decoded_q[$];
  logic [3:0]    nib_q[$];

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int mismatch_count = 0;
  int results_seen   = 0;
  int runs_seen      = 0;
  int done_seen      = 0;
  int fail_seen      = 0;
  int bytes_sent     = 0;

  file_order_run_decoder_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_seq_byte       (in_seq_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_run_start     (out_run_start),
    .out_run_length    (out_run_length),
    .out_total_entries (out_total_entries),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_file_count    (cfg_file_count)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void clear_decode();
    m_acc       = '0;
    m_shift     = 0;
    m_jump      = 1'b0;
    m_emit_next = 1'b1;
    m_pos       = '0;
    m_entries   = '0;
    m_failed    = 1'b0;
  endfunction

  function automatic logic [63:0] run_limit();
    return (m_file_count > LIMIT_CAP) ? 64'(LIMIT_CAP) : 64'(m_file_count);
  endfunction

  function automatic logic [63:0] pos_clip(logic [63:0] x);
    return (x > 64'(POS_SAT)) ? 64'(POS_SAT) : x;
  endfunction

  function automatic nib_outcome_t decode_nibble(input logic [3:0] nib,
                                                 output logic [63:0] start,
                                                 output logic [63:0] len);
    logic [63:0] v;
    logic [63:0] number;
    logic [63:0] lim;
    v     = 64'(nib[VAL_BITS-1:0]);
    start = '0;
    len   = '0;
    if (m_shift >= NB) begin
      if (v != 0) return NIB_FAIL;
    end else begin
      if ((v >> (NB - m_shift)) != 0) return NIB_FAIL;
      m_acc |= v << m_shift;
    end
    if (nib[CONT_BIT]) begin
      m_shift += VAL_BITS;
      if (m_shift > NB) m_shift = NB;
      return NIB_NONE;
    end
    number  = m_acc;
    m_acc   = '0;
    m_shift = 0;
    if (m_jump) begin
      m_pos       = pos_clip(number);
      m_emit_next = 1'b1;
      m_jump      = 1'b0;
      return NIB_NONE;
    end
    if (number == 0) begin
      m_jump = 1'b1;
      return NIB_NONE;
    end
    if (!m_emit_next) begin
      m_pos       = pos_clip(m_pos + number);
      m_emit_next = 1'b1;
      return NIB_NONE;
    end
    lim = run_limit();
    if (m_entries + number > lim || m_pos + number > lim) return NIB_FAIL;
    start       = m_pos;
    len         = number;
    m_entries  += number;
    m_pos       = pos_clip(m_pos + number);
    m_emit_next = 1'b0;
    return NIB_RUN;
  endfunction

  function automatic void push_word(kind_t kind, logic [63:0] start, logic [63:0] len);
    decoded_q.push_back('{kind, start[15:0], len[16:0], m_entries[16:0], 1'b0});
  endfunction

  function automatic void predict_decode(logic [7:0] b, bit fin);
    logic [63:0]  start;
    logic [63:0]  len;
    logic [3:0]   nib;
    nib_outcome_t r;
    bit           err_now;
    int           n;
    err_now = 1'b0;
    n       = 0;
    if (!m_failed) begin
      for (int half = 0; half < 2; half++) begin
        nib = (half == 0) ? b[7:4] : b[3:0];
        r   = decode_nibble(nib, start, len);
        if (r == NIB_RUN) begin
          push_word(KIND_RUN, start, len);
          n++;
        end else if (r == NIB_FAIL) begin
          m_failed = 1'b1;
          err_now  = 1'b1;
          push_word(KIND_FAIL, '0, '0);
          n++;
          break;
        end
      end
    end
    if (fin) begin
      if (!err_now) begin
        push_word((m_failed || m_shift != 0) ? KIND_FAIL : KIND_DONE, '0, '0);
        n++;
      end
      clear_decode();
    end
    if (n > 0) decoded_q[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch, %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    decoded_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_result_kind), '0);
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 32'(out_result_kind), 32'(want.kind));
        check_field("run_start", 32'(out_run_start), 32'(want.start));
        check_field("run_length", 32'(out_run_length), 32'(want.len));
        check_field("total_entries", 32'(out_total_entries), 32'(want.total));
        check_field("last", 32'(out_last), 32'(want.last));
        case (want.kind)
          KIND_RUN:  runs_seen++;
          KIND_DONE: done_seen++;
          default:   fail_seen++;
        endcase
      end
    end
  end

  // output side: random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 10) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_byte(logic [7:0] b, bit fin);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_seq_byte  <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
    predict_decode(b, fin);
    bytes_sent++;
  endtask

  // sender pauses until every expected word is back, then lets the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_file_count(logic [16:0] value);
    wait_drained();
    cfg_valid      <= 1'b1;
    cfg_file_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    m_file_count = value;
  endtask

  task automatic push_number(logic [63:0] n);
    do begin
      nib_q.push_back({n > 7, n[2:0]});
      n = n >> VAL_BITS;
    end while (n != 0);
  endtask

  task automatic send_sequence(seq_shape_t shape);
    logic [63:0] lim;
    bit          emit_next;
    int          nbytes;
    nib_q.delete();
    lim       = run_limit();
    emit_next = 1'b1;
    if (shape == SEQ_NOISE) begin
      nbytes = $urandom_range(1, 6);
      for (int i = 0; i < nbytes; i++)
        send_byte(8'($urandom), (i == nbytes - 1) || ($urandom_range(0, 9) == 0));
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 9) == 0) begin
        push_number('0);
        if ($urandom_range(0, 7) == 0) push_number(64'($urandom));
        else push_number(64'($urandom_range(0, 32'(lim >> 1))));
        emit_next = 1'b1;
      end else if (emit_next) begin
        if ($urandom_range(0, 15) == 0) push_number(64'($urandom_range(1, 70000)));
        else push_number(64'($urandom_range(1, 12)));
        emit_next = 1'b0;
      end else begin
        push_number(64'($urandom_range(1, 20)));
        emit_next = 1'b1;
      end
    end
    if (shape == SEQ_WIDE) begin
      if ($urandom_range(0, 1)) begin
        repeat (12) nib_q.push_back(4'hF);
      end else begin
        repeat (12) nib_q.push_back(4'h8);
        nib_q.push_back(4'h1);
      end
      push_number(64'($urandom_range(1, 9)));
    end
    if (shape == SEQ_DANGLING) begin
      nib_q.push_back({1'b1, 3'($urandom)});
      if (nib_q.size() % 2) nib_q.push_back({1'b1, 3'($urandom)});
    end
    if (nib_q.size() % 2) nib_q.push_back(4'h0);
    nbytes = nib_q.size() / 2;
    for (int i = 0; i < nbytes; i++)
      send_byte({nib_q[2*i], nib_q[2*i+1]}, i == nbytes - 1);
  endtask

  task automatic run_random_phase(logic [16:0] fc, int count);
    int stop_at;
    int r;
    write_file_count(fc);
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75)      send_sequence(SEQ_GOOD);
      else if (r < 85) send_sequence(SEQ_DANGLING);
      else if (r < 93) send_sequence(SEQ_WIDE);
      else             send_sequence(SEQ_NOISE);
    end
  endtask

  // ---------------------------------------------------------------- tests
  // file count is zero out of reset, so any run is over the limit
  task automatic test_reset_file_count();
    send_byte(8'h10, 1'b1);
  endtask

  task automatic test_runs_and_jumps();
    write_file_count(17'h1FFFF);
    send_byte(8'h35, 1'b0);  // emit 3, skip 5
    send_byte(8'h20, 1'b0);  // emit 2, zero marker
    send_byte(8'hCC, 1'b0);  // jump target, low groups
    send_byte(8'h17, 1'b0);  // jump to 100, emit 7
    send_byte(8'h00, 1'b1);  // marker then jump to 0
  endtask

  // a run ending exactly on the limit passes, one past it fails
  task automatic test_run_limit();
    write_file_count(17'd16);
    send_byte(8'h82, 1'b1);
    send_byte(8'h82, 1'b0);
    send_byte(8'h11, 1'b1);
  endtask

  // shift saturates, then a nonzero group errors; failed bytes stay silent
  task automatic test_wide_numbers();
    write_file_count(17'h10000);
    repeat (5) send_byte(8'h88, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_dangling_continuation();
    send_byte(8'h18, 1'b1);
  endtask

  // jump to the top 32-bit value saturates the position
  task automatic test_large_position();
    send_byte(8'h0F, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(8'h10, 1'b1);
  endtask

  // output held for a long stretch while words keep coming in
  task automatic test_output_hold();
    write_file_count(17'h10000);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_byte(8'h11, i == 23);
    wait_drained();
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_sender_pause();
    send_sequence(SEQ_GOOD);
    wait_drained();
    send_sequence(SEQ_GOOD);
  endtask

  task automatic test_random_sequences();
    run_random_phase(17'd200, 45);
    run_random_phase(17'h10000, 40);
    run_random_phase(17'd7, 35);
    run_random_phase(17'h1FFFF, 35);
    run_random_phase(17'd1, 15);
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    run_random_phase(17'd3000, 40);
  endtask

  // ---------------------------------------------------------------- run
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_seq_byte    = '0;
    in_last_byte   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_file_count = '0;
    m_file_count   = '0;
    clear_decode();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_file_count();
    test_runs_and_jumps();
    test_run_limit();
    test_wide_numbers();
    test_dangling_continuation();
    test_large_position();
    test_output_hold();
    test_sender_pause();
    test_random_sequences();
    test_quiet_tail();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("decoded %0d bytes into %0d words: %0d runs, %0d clean ends, %0d format errors",
             bytes_sent, results_seen, runs_seen, done_seen, fail_seen);
    $display("file counts 0 to 0x1FFFF, one %0d-cycle output hold, %0d mismatches",
             HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d words still expected", decoded_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
